// ===== hw/rtl/ipt_pkg.sv =====
// shared types, constants and helpers of the injector pulse timing unit
package ipt_pkg;

  localparam int TIMER_BITS = 16;

  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_EDGE   = 2'd1;
  localparam logic [1:0] REQ_SENSOR = 2'd2;

  localparam logic [15:0] THRESHOLD_RST = 16'd2500;
  localparam logic [15:0] PULSE_RST     = 16'd30;
  localparam logic [15:0] SAT_TICKS     = 16'hFFFF;

  localparam int MAP_FULL = 1023;
  localparam int ACC_W    = 54;
  localparam int ON_QBITS = 11;
  localparam int DEN_W    = 43;
  localparam int DD_W     = DEN_W + ON_QBITS - 1;
  localparam int K_W      = 38;

  localparam logic [DEN_W-1:0] ON_DEN = 43'd8142336816831;

  typedef struct packed {
    logic        done;
    logic [15:0] hold;
    logic [15:0] pulse;
  } ipt_res_t;

  typedef struct packed {
    logic        drive;
    logic        started;
    logic        ended;
    logic        skipped;
    logic [15:0] hold;
    logic [15:0] pulse;
  } ipt_view_t;

  // (1000*q + 425) * 31250000 for pressure step q
  function automatic logic [K_W-1:0] ipt_k(input logic [2:0] q);
    logic [K_W-1:0] k;
    case (q)
      3'd0:    k = 38'd13281250000;
      3'd1:    k = 38'd44531250000;
      3'd2:    k = 38'd75781250000;
      3'd3:    k = 38'd107031250000;
      3'd4:    k = 38'd138281250000;
      3'd5:    k = 38'd169531250000;
      default: k = 38'd169531250000;
    endcase
    return k;
  endfunction

  function automatic logic [TIMER_BITS-1:0] ipt_fit(input logic [15:0] v);
    return TIMER_BITS'(v);
  endfunction

endpackage

// ===== hw/rtl/injector_pulse_timing_unit.sv =====
// top level of the injector pulse timing unit
// Every input transaction yields exactly one result transaction. A timer tick,
// a crank edge or an unused request code passes the timer state into the output
// register, waiting in that state while the output register holds an untaken
// result. A sensor update runs the bit-serial chain of rpm/60 (16 steps), 1000/s
// (10 steps), the shift-add multiply by rpm (16 steps) and the restoring division
// by the scale factor (11 steps); when rpm/60 is zero it ends after the first
// division, and when rpm is not above the threshold it ends before the multiply.
// One item is in work at a time; a new one is taken while the previous result
// still waits in the output register. The threshold register may be written at
// any time the unit is idle and takes effect on the next sensor update.
module injector_pulse_timing_unit
  import ipt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // rpm[15:0], map_raw[25:16], zero fill
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // injector_drive[0], pulse_started[1], pulse_ended[2],
                                  // pulse_skipped[3], delay_value[19:4],
                                  // on_time_value[35:20], zero fill
  input  logic        cfg_tvalid,
  output logic        cfg_tready,
  input  logic [15:0] cfg_tdata   // rpm_threshold[15:0]
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_TIMER = 2'd1;
  localparam logic [1:0] ST_CALC  = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]  st_r, st_nxt;
  logic [1:0]  req_r;
  logic [15:0] thr_r;
  logic        out_valid_r, out_valid_nxt;
  logic [39:0] out_data_r, out_data_nxt;

  logic      in_acc;
  logic      slot_free;
  logic      step;
  logic      calc_start;
  ipt_res_t  res;
  ipt_view_t view;

  assign in_tready  = st_r == ST_IDLE;
  assign in_acc     = in_tvalid && in_tready;
  assign slot_free  = !out_valid_r || out_tready;
  assign calc_start = in_acc && (in_tuser == REQ_SENSOR);
  assign step       = (st_r == ST_TIMER) && slot_free;
  assign cfg_tready = 1'b1;

  ipt_calc u_calc (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (calc_start),
    .rpm       (in_tdata[15:0]),
    .map_raw   (in_tdata[25:16]),
    .threshold (thr_r),
    .res       (res)
  );

  ipt_timer u_timer (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .req   (req_r),
    .load  (res),
    .view  (view)
  );

  always_comb begin
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          st_nxt = (in_tuser == REQ_SENSOR) ? ST_CALC : ST_TIMER;
        end
      end
      ST_CALC: begin
        if (res.done) begin
          st_nxt = ST_EMIT;
        end
      end
      ST_TIMER, ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {4'b0, view.pulse, view.hold, view.skipped, view.ended,
                           view.started, view.drive};
          st_nxt        = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
      thr_r       <= THRESHOLD_RST;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_tvalid && cfg_tready) begin
        thr_r <= cfg_tdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (in_acc) begin
      req_r <= in_tuser;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== hw/rtl/ipt_calc.sv =====
// serial arithmetic for the sensor update: rpm/60, 1000/s, rpm*k and division by the scale
module ipt_calc
  import ipt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] rpm,
  input  logic [9:0]  map_raw,
  input  logic [15:0] threshold,
  output ipt_res_t    res
);

  localparam logic [2:0] C_IDLE  = 3'd0;
  localparam logic [2:0] C_DIV60 = 3'd1;
  localparam logic [2:0] C_DIV1K = 3'd2;
  localparam logic [2:0] C_PER   = 3'd3;
  localparam logic [2:0] C_MUL   = 3'd4;
  localparam logic [2:0] C_DIVD  = 3'd5;

  logic [2:0]       st_r, st_nxt;
  logic             done_r, done_nxt;
  logic [3:0]       cnt_r, cnt_nxt;
  logic [15:0]      quo_r, quo_nxt;
  logic [10:0]      rem_r, rem_nxt;
  logic [10:0]      sdiv_r, sdiv_nxt;
  logic [15:0]      mul_r, mul_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [DD_W-1:0]  dd_r, dd_nxt;
  logic [2:0]       q_r, q_nxt;
  logic             above_r, above_nxt;
  logic [15:0]      hold_r, hold_nxt;
  logic [15:0]      pulse_r, pulse_nxt;

  logic [12:0] raw5;
  logic [2:0]  qv;
  logic [6:0]  t60;
  logic        ge60;
  logic [11:0] t1k;
  logic        ge1k;
  logic [9:0]  per;
  logic [16:0] p125;
  logic [16:0] p25;
  logic        gedd;

  assign raw5 = {1'b0, map_raw, 2'b00} + {3'b000, map_raw};

  always_comb begin
    if (raw5 >= 13'(5 * MAP_FULL)) begin
      qv = 3'd5;
    end else if (raw5 >= 13'(4 * MAP_FULL)) begin
      qv = 3'd4;
    end else if (raw5 >= 13'(3 * MAP_FULL)) begin
      qv = 3'd3;
    end else if (raw5 >= 13'(2 * MAP_FULL)) begin
      qv = 3'd2;
    end else if (raw5 >= 13'(MAP_FULL)) begin
      qv = 3'd1;
    end else begin
      qv = 3'd0;
    end
  end

  assign t60  = {rem_r[5:0], quo_r[15]};
  assign ge60 = t60 >= 7'd60;
  assign t1k  = {rem_r, quo_r[15]};
  assign ge1k = t1k >= {1'b0, sdiv_r};
  assign per  = quo_r[9:0];
  assign p125 = {per, 7'b0} - {6'b0, per, 1'b0} - {7'b0, per};
  assign p25  = {3'b0, per, 4'b0} + {4'b0, per, 3'b0} + {7'b0, per};
  assign gedd = acc_r >= {1'b0, dd_r};

  always_comb begin
    st_nxt    = st_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    sdiv_nxt  = sdiv_r;
    mul_nxt   = mul_r;
    acc_nxt   = acc_r;
    dd_nxt    = dd_r;
    q_nxt     = q_r;
    above_nxt = above_r;
    hold_nxt  = hold_r;
    pulse_nxt = pulse_r;
    case (st_r)
      C_IDLE: begin
        if (start) begin
          quo_nxt   = rpm;
          rem_nxt   = '0;
          mul_nxt   = rpm;
          q_nxt     = qv;
          above_nxt = rpm > threshold;
          cnt_nxt   = 4'd15;
          st_nxt    = C_DIV60;
        end
      end
      C_DIV60: begin
        rem_nxt = 11'(ge60 ? t60 - 7'd60 : t60);
        quo_nxt = {quo_r[14:0], ge60};
        cnt_nxt = cnt_r - 4'd1;
        if (cnt_r == 4'd0) begin
          if (quo_nxt == 16'd0) begin
            hold_nxt  = SAT_TICKS;
            pulse_nxt = SAT_TICKS;
            done_nxt  = 1'b1;
            st_nxt    = C_IDLE;
          end else begin
            sdiv_nxt = quo_nxt[10:0];
            quo_nxt  = {10'd1000, 6'b0};
            rem_nxt  = '0;
            cnt_nxt  = 4'd9;
            st_nxt   = C_DIV1K;
          end
        end
      end
      C_DIV1K: begin
        rem_nxt = 11'(ge1k ? t1k - {1'b0, sdiv_r} : t1k);
        quo_nxt = {quo_r[14:0], ge1k};
        cnt_nxt = cnt_r - 4'd1;
        if (cnt_r == 4'd0) begin
          st_nxt = C_PER;
        end
      end
      C_PER: begin
        hold_nxt = 16'(p125 >> 2);
        if (above_r) begin
          acc_nxt = '0;
          cnt_nxt = 4'd15;
          st_nxt  = C_MUL;
        end else begin
          pulse_nxt = 16'(p25 >> 2);
          done_nxt  = 1'b1;
          st_nxt    = C_IDLE;
        end
      end
      C_MUL: begin
        acc_nxt = {acc_r[ACC_W-2:0], 1'b0} + (mul_r[15] ? ACC_W'(ipt_k(q_r)) : '0);
        mul_nxt = {mul_r[14:0], 1'b0};
        cnt_nxt = cnt_r - 4'd1;
        if (cnt_r == 4'd0) begin
          dd_nxt  = {ON_DEN, (ON_QBITS - 1)'(0)};
          quo_nxt = '0;
          cnt_nxt = 4'(ON_QBITS - 1);
          st_nxt  = C_DIVD;
        end
      end
      C_DIVD: begin
        acc_nxt = gedd ? acc_r - {1'b0, dd_r} : acc_r;
        dd_nxt  = dd_r >> 1;
        quo_nxt = {quo_r[14:0], gedd};
        cnt_nxt = cnt_r - 4'd1;
        if (cnt_r == 4'd0) begin
          pulse_nxt = quo_nxt;
          done_nxt  = 1'b1;
          st_nxt    = C_IDLE;
        end
      end
      default: begin
        st_nxt = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= C_IDLE;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    sdiv_r  <= sdiv_nxt;
    mul_r   <= mul_nxt;
    acc_r   <= acc_nxt;
    dd_r    <= dd_nxt;
    q_r     <= q_nxt;
    above_r <= above_nxt;
    hold_r  <= hold_nxt;
    pulse_r <= pulse_nxt;
  end

  assign res.done  = done_r;
  assign res.hold  = hold_r;
  assign res.pulse = pulse_r;

endmodule

// ===== hw/rtl/ipt_timer.sv =====
// crank phase sequencer: hold-off, drive pulse, alternation and tick counter
module ipt_timer
  import ipt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [1:0] req,
  input  ipt_res_t   load,
  output ipt_view_t  view
);

  logic                  armed_r, armed_nxt;
  logic                  second_r, second_nxt;
  logic                  skip_r, skip_nxt;
  logic [TIMER_BITS-1:0] tick_r, tick_nxt;
  logic [TIMER_BITS-1:0] cmp_r, cmp_nxt;
  logic [15:0]           hold_r, hold_nxt;
  logic [15:0]           pulse_r, pulse_nxt;
  logic                  drive_r, drive_nxt;
  logic                  started, ended, skipped;

  always_comb begin
    armed_nxt  = armed_r;
    second_nxt = second_r;
    skip_nxt   = skip_r;
    tick_nxt   = tick_r;
    cmp_nxt    = cmp_r;
    hold_nxt   = hold_r;
    pulse_nxt  = pulse_r;
    drive_nxt  = drive_r;
    started    = 1'b0;
    ended      = 1'b0;
    skipped    = 1'b0;
    if (step) begin
      case (req)
        REQ_TICK: begin
          if (!armed_r) begin
            if (tick_r == cmp_r) begin
              tick_nxt = '0;
              if (!second_r) begin
                if (!skip_r) begin
                  drive_nxt = 1'b1;
                  cmp_nxt   = ipt_fit(pulse_r);
                  started   = 1'b1;
                end else begin
                  skipped = 1'b1;
                end
                second_nxt = 1'b1;
              end else begin
                drive_nxt  = 1'b0;
                skip_nxt   = !skip_r;
                second_nxt = 1'b0;
                armed_nxt  = 1'b1;
                ended      = 1'b1;
              end
            end else begin
              tick_nxt = tick_r + 1'b1;
            end
          end
        end
        REQ_EDGE: begin
          if (armed_r) begin
            armed_nxt  = 1'b0;
            second_nxt = 1'b0;
            tick_nxt   = '0;
            cmp_nxt    = ipt_fit(hold_r);
          end
        end
        default: begin
        end
      endcase
    end
    if (load.done) begin
      hold_nxt  = load.hold;
      pulse_nxt = load.pulse;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r  <= 1'b1;
      second_r <= 1'b0;
      skip_r   <= 1'b0;
      tick_r   <= '0;
      cmp_r    <= '0;
      hold_r   <= '0;
      pulse_r  <= PULSE_RST;
      drive_r  <= 1'b0;
    end else begin
      armed_r  <= armed_nxt;
      second_r <= second_nxt;
      skip_r   <= skip_nxt;
      tick_r   <= tick_nxt;
      cmp_r    <= cmp_nxt;
      hold_r   <= hold_nxt;
      pulse_r  <= pulse_nxt;
      drive_r  <= drive_nxt;
    end
  end

  assign view.drive   = drive_nxt;
  assign view.started = started;
  assign view.ended   = ended;
  assign view.skipped = skipped;
  assign view.hold    = hold_r;
  assign view.pulse   = pulse_r;

endmodule

// ===== tb/sv/testbench.sv =====
// self-checking testbench of the injector pulse timing unit
module testbench;
  import ipt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam longint unsigned SCALE_NUM = 64'd31250000;
  localparam longint unsigned SCALE_DEN = 64'd8142336816831;
  localparam int STALL_LIMIT = 4000;
  localparam int BACKLOG_CYCLES = 400;
  localparam int CFG_SETTLE = 4;
  localparam int END_SETTLE = 64;
  localparam int PHASE_ITEMS = 125;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [1:0]  req;
    logic [15:0] rpm;    // threshold value on ROW_CFG rows
    logic [9:0]  raw;
    bit          typed;
    ipt_view_t   want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        cfg_tvalid;
  logic        cfg_tready;
  logic [15:0] cfg_tdata;

  // predictor state
  logic [15:0]           threshold;
  bit                    armed;
  bit                    fire_phase;
  bit                    skip_alt;
  bit                    drive_open;
  logic [TIMER_BITS-1:0] tick_cnt;
  logic [TIMER_BITS-1:0] tick_limit;
  logic [15:0]           hold_ticks;
  logic [15:0]           on_ticks;

  ipt_view_t pending_views[$];
  int        mismatches = 0;
  int        stall_cycles = 0;
  bit        steady = 1'b0;
  bit        backlog_req = 1'b0;

  plan_row_t plan_rows [26] = '{
    '{ROW_ITEM, REQ_TICK,   16'd0,     10'd0,     1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 16'd30}},
    '{ROW_ITEM, REQ_UNUSED, 16'hFFFF,  10'h3FF,   1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 16'd30}},
    '{ROW_ITEM, REQ_SENSOR, 16'd0,     10'd0,     1'b1,
      '{1'b0, 1'b0, 1'b0, 1'b0, 16'hFFFF, 16'hFFFF}},
    '{ROW_ITEM, REQ_SENSOR, 16'd59,    10'h3FF,   1'b1,
      '{1'b0, 1'b0, 1'b0, 1'b0, 16'hFFFF, 16'hFFFF}},
    '{ROW_ITEM, REQ_SENSOR, 16'd60,    10'd0,     1'b1,
      '{1'b0, 1'b0, 1'b0, 1'b0, 16'd31250, 16'd6250}},
    '{ROW_ITEM, REQ_SENSOR, 16'd2500,  10'd512,   1'b1,
      '{1'b0, 1'b0, 1'b0, 1'b0, 16'd750, 16'd150}},
    '{ROW_ITEM, REQ_SENSOR, 16'd2501,  10'd0,     1'b0, '0},
    '{ROW_ITEM, REQ_SENSOR, 16'hFFFF,  10'h3FF,   1'b0, '0},
    '{ROW_CFG,  REQ_TICK,   16'hFFFF,  10'd0,     1'b0, '0},
    // zero hold-off and zero on-time: every phase lasts one tick
    '{ROW_ITEM, REQ_SENSOR, 16'hFFFF,  10'h3FF,   1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0}},
    '{ROW_ITEM, REQ_EDGE,   16'hFFFF,  10'h3FF,   1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0}},
    '{ROW_ITEM, REQ_EDGE,   16'd0,     10'd0,     1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0}},
    '{ROW_ITEM, REQ_TICK,   16'hAAAA,  10'h155,   1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 16'd0, 16'd0}},
    '{ROW_ITEM, REQ_SENSOR, 16'd60,    10'd0,     1'b1,
      '{1'b1, 1'b0, 1'b0, 1'b0, 16'd31250, 16'd6250}},
    '{ROW_ITEM, REQ_TICK,   16'h5555,  10'h2AA,   1'b1,
      '{1'b0, 1'b0, 1'b1, 1'b0, 16'd31250, 16'd6250}},
    '{ROW_ITEM, REQ_SENSOR, 16'hFFFF,  10'd0,     1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0}},
    '{ROW_ITEM, REQ_EDGE,   16'd0,     10'd0,     1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0}},
    '{ROW_ITEM, REQ_TICK,   16'd0,     10'd0,     1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 16'd0, 16'd0}},
    '{ROW_ITEM, REQ_TICK,   16'd0,     10'd0,     1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 16'd0, 16'd0}},
    '{ROW_ITEM, REQ_TICK,   16'd0,     10'd0,     1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0}},
    '{ROW_ITEM, REQ_EDGE,   16'd0,     10'd0,     1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0}},
    '{ROW_ITEM, REQ_TICK,   16'd0,     10'd0,     1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 16'd0, 16'd0}},
    '{ROW_ITEM, REQ_TICK,   16'd0,     10'd0,     1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 16'd0, 16'd0}},
    '{ROW_CFG,  REQ_TICK,   16'd0,     10'd0,     1'b0, '0},
    '{ROW_ITEM, REQ_SENSOR, 16'd60,    10'h3FF,   1'b0, '0},
    '{ROW_ITEM, REQ_SENSOR, 16'd0,     10'd0,     1'b1,
      '{1'b0, 1'b0, 1'b0, 1'b0, 16'hFFFF, 16'hFFFF}}
  };

  injector_pulse_timing_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // rpm[15:0], map_raw[25:16], zero fill
    .in_tuser   (in_tuser),    // req_type[1:0]
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // drive[0], started[1], ended[2], skipped[3],
                               // delay[19:4], on_time[35:20], zero fill
    .cfg_tvalid (cfg_tvalid),
    .cfg_tready (cfg_tready),
    .cfg_tdata  (cfg_tdata)    // rpm_threshold[15:0]
  );

  always #6 clk = ~clk;

  function automatic void apply_sensor(input logic [15:0] rpm, input logic [9:0] raw);
    int unsigned      revs;
    int unsigned      period;
    int unsigned      step;
    longint unsigned  prod;
    revs = rpm / 60;
    if (revs == 0) begin
      hold_ticks = SAT_TICKS;
      on_ticks = SAT_TICKS;
      return;
    end
    period = 1000 / revs;
    hold_ticks = 16'((period * 125) / 4);
    if (rpm <= threshold) begin
      on_ticks = 16'((period * 25) / 4);
    end else begin
      step = (32'(raw) * 5) / 1023;
      prod = 64'(rpm) * 64'(1000 * step + 425) * SCALE_NUM;
      on_ticks = 16'(prod / SCALE_DEN);
    end
  endfunction

  function automatic ipt_view_t advance_injector(input logic [1:0] req, input logic [15:0] rpm,
                                                 input logic [9:0] raw);
    ipt_view_t res;
    res = '0;
    case (req)
      REQ_TICK: begin
        if (!armed) begin
          if (tick_cnt == tick_limit) begin
            tick_cnt = '0;
            if (!fire_phase) begin
              if (!skip_alt) begin
                drive_open = 1'b1;
                tick_limit = TIMER_BITS'(on_ticks);
                res.started = 1'b1;
              end else begin
                res.skipped = 1'b1;
              end
              fire_phase = 1'b1;
            end else begin
              drive_open = 1'b0;
              skip_alt = !skip_alt;
              fire_phase = 1'b0;
              armed = 1'b1;
              res.ended = 1'b1;
            end
          end else begin
            tick_cnt = tick_cnt + 1'b1;
          end
        end
      end
      REQ_EDGE: begin
        if (armed) begin
          armed = 1'b0;
          fire_phase = 1'b0;
          tick_cnt = '0;
          tick_limit = TIMER_BITS'(hold_ticks);
        end
      end
      REQ_SENSOR: apply_sensor(rpm, raw);
      default: ;
    endcase
    res.drive = drive_open;
    res.hold = hold_ticks;
    res.pulse = on_ticks;
    return res;
  endfunction

  task automatic send_item(input logic [1:0] req, input logic [15:0] rpm, input logic [9:0] raw,
                           input bit typed, input ipt_view_t want);
    int        pick;
    int        gap;
    ipt_view_t predicted;
    pick = $urandom_range(0, 99);
    if (steady || pick < 55) gap = 0;
    else if (pick < 85) gap = $urandom_range(1, 3);
    else if (pick < 97) gap = $urandom_range(4, 12);
    else gap = $urandom_range(20, 60);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= req;
    in_tdata <= {6'd0, raw, rpm};
    do @(posedge clk); while (!in_tready);
    predicted = advance_injector(req, rpm, raw);
    pending_views.push_back(typed ? want : predicted);
  endtask

  task automatic write_threshold(input logic [15:0] value);
    in_tvalid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (CFG_SETTLE) @(posedge clk);
    cfg_tvalid <= 1'b1;
    cfg_tdata <= value;
    do @(posedge clk); while (!cfg_tready);
    threshold = value;
    cfg_tvalid <= 1'b0;
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    ipt_view_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_views.size() == 0) begin
        $error("result transaction with nothing expected");
        mismatches++;
      end else begin
        want = pending_views.pop_front();
        check_field("injector_drive", want.drive, out_tdata[0]);
        check_field("pulse_started", want.started, out_tdata[1]);
        check_field("pulse_ended", want.ended, out_tdata[2]);
        check_field("pulse_skipped", want.skipped, out_tdata[3]);
        check_field("delay_value", want.hold, out_tdata[19:4]);
        check_field("on_time_value", want.pulse, out_tdata[35:20]);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_tvalid && cfg_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("** injector_pulse_timing_unit: FAILED **");
      $finish;
    end
  end

  initial begin : result_sink
    int pick;
    int gap;
    out_tready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      pick = $urandom_range(0, 99);
      if (backlog_req) begin
        backlog_req = 1'b0;
        gap = BACKLOG_CYCLES;
      end else if (steady || pick < 60) begin
        gap = 0;
      end else if (pick < 90) begin
        gap = $urandom_range(1, 3);
      end else if (pick < 97) begin
        gap = $urandom_range(4, 20);
      end else begin
        gap = $urandom_range(40, 120);
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin : stimulus
    int          pick;
    int          useful_items;
    bit          useful;
    logic [1:0]  req;
    logic [15:0] rpm;
    logic [9:0]  raw;
    logic [15:0] phase_thr [5];
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = REQ_TICK;
    in_tdata = '0;
    cfg_tvalid = 1'b0;
    cfg_tdata = '0;
    threshold = THRESHOLD_RST;
    armed = 1'b1;
    fire_phase = 1'b0;
    skip_alt = 1'b0;
    drive_open = 1'b0;
    tick_cnt = '0;
    tick_limit = '0;
    hold_ticks = '0;
    on_ticks = PULSE_RST;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan_rows[i]) begin
      if (plan_rows[i].kind == ROW_CFG) begin
        write_threshold(plan_rows[i].rpm);
      end else begin
        send_item(plan_rows[i].req, plan_rows[i].rpm, plan_rows[i].raw, plan_rows[i].typed,
                  plan_rows[i].want);
      end
    end

    phase_thr = '{16'hFFFF, 16'($urandom_range(20000, 65535)), 16'd0, THRESHOLD_RST,
                  16'($urandom)};
    for (int p = 0; p < 5; p++) begin
      write_threshold(phase_thr[p]);
      steady = (p == 1);
      // receiver holds off while items keep coming
      if (p == 3) backlog_req = 1'b1;
      useful_items = 0;
      while (useful_items < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        rpm = 16'($urandom);
        raw = 10'($urandom);
        if (armed) begin
          req = pick < 50 ? REQ_EDGE : pick < 85 ? REQ_SENSOR : pick < 95 ? REQ_TICK : REQ_UNUSED;
        end else begin
          req = pick < 85 ? REQ_TICK : pick < 93 ? REQ_SENSOR : pick < 98 ? REQ_EDGE : REQ_UNUSED;
        end
        // mostly high speeds so that hold-off and on-time stay short
        if (req == REQ_SENSOR) begin
          if ($urandom_range(0, 24) != 0) rpm = 16'($urandom_range(20000, 65535));
          if ($urandom_range(0, 1) != 0) raw = 10'($urandom_range(0, 204));
        end
        useful = !((req == REQ_TICK && armed) || (req == REQ_EDGE && !armed) ||
                   req == REQ_UNUSED);
        send_item(req, rpm, raw, 1'b0, '0);
        if (useful) useful_items++;
      end
    end
    steady = 1'b0;

    in_tvalid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (END_SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("** injector_pulse_timing_unit: PASSED **");
    end else begin
      $display("** injector_pulse_timing_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ===== injector_pulse_timing_unit.f =====
hw/rtl/ipt_pkg.sv
hw/rtl/ipt_calc.sv
hw/rtl/ipt_timer.sv
hw/rtl/injector_pulse_timing_unit.sv
tb/sv/testbench.sv
